/* rtl/banked_memory_mapper_assert.svh */
// Assertion macros used by the mapper's top-level RTL file.
`ifndef BANKED_MEMORY_MAPPER_ASSERT_SVH
`define BANKED_MEMORY_MAPPER_ASSERT_SVH

`ifndef SYNTH

`define BMM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mapper assertion failed");

`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mapper assertion failed");

`else

`define BMM_ASSERT_IMPL(label, clk, rst, ante, cons)

`define BMM_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/bmm_pkg.sv */
package bmm_pkg;

   // System RAM depth must be a power of two no deeper than the cart RAM.
   localparam int SYS_RAM_DEPTH  = 8192;
   localparam int CART_RAM_DEPTH = 32768;
   localparam int ROM_ADDR_BITS  = 20;

   localparam int SYS_IDX_W  = $clog2(SYS_RAM_DEPTH);
   localparam int CART_IDX_W = $clog2(CART_RAM_DEPTH);
   localparam int ADDR_W     = 16;
   localparam int DATA_W     = 8;
   localparam int ROM_W      = 20;
   localparam int BANK_W     = 6;
   localparam int OFFSET_W   = 14;

   localparam logic [ROM_W-1:0] ROM_MASK = ROM_W'((64'd1 << ROM_ADDR_BITS) - 64'd1);

   localparam logic CMD_WRITE = 1'b1;

   localparam logic [ADDR_W-1:0] ADDR_BOOT_END = 16'h0400;
   localparam logic [ADDR_W-1:0] ADDR_CTRL     = 16'hFFFC;
   localparam logic [ADDR_W-1:0] ADDR_BANK0    = 16'hFFFD;
   localparam logic [ADDR_W-1:0] ADDR_BANK1    = 16'hFFFE;
   localparam logic [ADDR_W-1:0] ADDR_BANK2    = 16'hFFFF;

   localparam logic [1:0] SLOT_0    = 2'd0;
   localparam logic [1:0] SLOT_1    = 2'd1;
   localparam logic [1:0] SLOT_CART = 2'd2;
   localparam logic [1:0] SLOT_SYS  = 2'd3;

   localparam int CTRL_RAM_EN_BIT   = 3;
   localparam int CTRL_RAM_BANK_BIT = 2;

   localparam logic [BANK_W-1:0] BANK0_RESET = 6'd0;
   localparam logic [BANK_W-1:0] BANK1_RESET = 6'd1;
   localparam logic [BANK_W-1:0] BANK2_RESET = 6'd2;

   typedef enum logic [1:0] {
      SRC_NONE = 2'd0,
      SRC_ROM  = 2'd1,
      SRC_SYS  = 2'd2,
      SRC_CART = 2'd3
   } source_type;

   typedef struct packed {
      source_type              src;
      logic [ROM_W-1:0]        rom_address;
      logic                    sys_we;
      logic                    sys_re;
      logic [SYS_IDX_W-1:0]    sys_idx;
      logic                    cart_we;
      logic                    cart_re;
      logic [CART_IDX_W-1:0]   cart_idx;
   } map_type;

   // Start-up contents of system RAM: the bytes mirrored at 0xFFFE and 0xFFFF
   // hold the initial bank numbers of slots 1 and 2.
   function automatic logic [DATA_W-1:0] sys_clear_value(input logic [SYS_IDX_W-1:0] idx);
      logic [DATA_W-1:0] value;
      value = '0;
      if (idx == SYS_IDX_W'(ADDR_BANK1)) begin
         value = DATA_W'(BANK1_RESET);
      end else if (idx == SYS_IDX_W'(ADDR_BANK2)) begin
         value = DATA_W'(BANK2_RESET);
      end
      return value;
   endfunction

endpackage

/* rtl/bmm_ram.sv */
module bmm_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/bmm_map.sv */
module bmm_map (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          cmd,
   input  logic [bmm_pkg::ADDR_W-1:0]    address,
   input  logic [bmm_pkg::DATA_W-1:0]    write_data,
   output bmm_pkg::map_type              map,
   output logic                          battery_in
);

   import bmm_pkg::*;

   logic              ram_en_ff, ram_en_in;
   logic              ram_bank_ff, ram_bank_in;
   logic              battery_ff;
   logic [BANK_W-1:0] bank0_ff, bank0_in;
   logic [BANK_W-1:0] bank1_ff, bank1_in;
   logic [BANK_W-1:0] bank2_ff, bank2_in;
   logic [BANK_W-1:0] slot_bank;
   logic [1:0]        slot;
   logic              is_write;
   logic              reg_write;

   assign slot     = address[ADDR_W-1 -: 2];
   assign is_write = (cmd == CMD_WRITE);

   always_comb begin
      unique case (slot)
         SLOT_0:    slot_bank = bank0_ff;
         SLOT_1:    slot_bank = bank1_ff;
         SLOT_CART: slot_bank = bank2_ff;
         default:   slot_bank = bank2_ff;
      endcase
   end

   always_comb begin
      map          = '0;
      map.src      = SRC_NONE;
      map.sys_idx  = address[SYS_IDX_W-1:0];
      map.cart_idx = CART_IDX_W'({ram_bank_ff, address[OFFSET_W-1:0]});
      if (!is_write) begin
         if (address < ADDR_BOOT_END) begin
            map.src         = SRC_ROM;
            map.rom_address = ROM_W'(address) & ROM_MASK;
         end else if (slot != SLOT_SYS) begin
            if (slot == SLOT_CART && ram_en_ff) begin
               map.src     = SRC_CART;
               map.cart_re = 1'b1;
            end else begin
               map.src         = SRC_ROM;
               map.rom_address = {slot_bank, address[OFFSET_W-1:0]} & ROM_MASK;
            end
         end else begin
            map.src    = SRC_SYS;
            map.sys_re = 1'b1;
         end
      end else begin
         if (slot == SLOT_SYS) begin
            map.src    = SRC_SYS;
            map.sys_we = 1'b1;
         end else if (slot == SLOT_CART && ram_en_ff) begin
            map.src     = SRC_CART;
            map.cart_we = 1'b1;
         end
      end
   end

   // Register writes land at the acceptance edge, so the very next request
   // already decodes through the new banks.
   assign reg_write = accept && is_write;

   always_comb begin
      ram_en_in   = ram_en_ff;
      ram_bank_in = ram_bank_ff;
      bank0_in    = bank0_ff;
      bank1_in    = bank1_ff;
      bank2_in    = bank2_ff;
      battery_in  = battery_ff;
      if (reg_write) begin
         priority if (address == ADDR_CTRL) begin
            ram_en_in   = write_data[CTRL_RAM_EN_BIT];
            ram_bank_in = write_data[CTRL_RAM_BANK_BIT];
            battery_in  = battery_ff | write_data[CTRL_RAM_EN_BIT];
         end else if (address == ADDR_BANK0) begin
            bank0_in = write_data[BANK_W-1:0];
         end else if (address == ADDR_BANK1) begin
            bank1_in = write_data[BANK_W-1:0];
         end else if (address == ADDR_BANK2) begin
            bank2_in = write_data[BANK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ram_en_ff   <= 1'b0;
         ram_bank_ff <= 1'b0;
         battery_ff  <= 1'b0;
         bank0_ff    <= BANK0_RESET;
         bank1_ff    <= BANK1_RESET;
         bank2_ff    <= BANK2_RESET;
      end else begin
         ram_en_ff   <= ram_en_in;
         ram_bank_ff <= ram_bank_in;
         battery_ff  <= battery_in;
         bank0_ff    <= bank0_in;
         bank1_ff    <= bank1_in;
         bank2_ff    <= bank2_in;
      end
   end

endmodule

/* rtl/banked_memory_mapper.sv */
// Channel   Handshake              Payload
// request   req_valid / req_ready  req_cmd, req_address, req_write_data
// response  rsp_valid / rsp_ready  rsp_source, rsp_rom_address, rsp_read_data,
//                                  rsp_battery_used
//
// One request is accepted per cycle while req_ready is high; its response
// appears in the next cycle, through the registered read port of the system
// and cart RAMs. After reset the RAMs are cleared one entry a cycle until every
// cart RAM entry is written, and req_ready stays low throughout.
// A stalled response holds req_ready low, so no RAM read is lost.
`include "banked_memory_mapper_assert.svh"

module banked_memory_mapper (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_cmd,
   input  logic [bmm_pkg::ADDR_W-1:0]          req_address,
   input  logic [bmm_pkg::DATA_W-1:0]          req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_source,
   output logic [bmm_pkg::ROM_W-1:0]           rsp_rom_address,
   output logic [bmm_pkg::DATA_W-1:0]          rsp_read_data,
   output logic                                rsp_battery_used
);

   import bmm_pkg::*;

   map_type                map;
   logic                   accept;
   logic                   battery_in;

   logic                   clearing_ff, clearing_in;
   logic [CART_IDX_W-1:0]  clr_cnt_ff, clr_cnt_in;

   logic                   sys_we, sys_re;
   logic [SYS_IDX_W-1:0]   sys_addr;
   logic [DATA_W-1:0]      sys_wdata, sys_q;
   logic                   cart_we, cart_re;
   logic [CART_IDX_W-1:0]  cart_addr;
   logic [DATA_W-1:0]      cart_q;

   logic                   s1_valid_ff, s1_valid_in;
   source_type             s1_src_ff;
   logic [ROM_W-1:0]       s1_rom_ff;
   logic                   s1_bat_ff;
   logic                   s1_ram_rd_ff;

   assign req_ready = !clearing_ff && (!s1_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   bmm_map u_map (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (req_cmd),
      .address    (req_address),
      .write_data (req_write_data),
      .map        (map),
      .battery_in (battery_in)
   );

   // Clearing sweep: the system RAM index wraps, so it is swept four times
   // while the cart RAM is swept once.
   always_comb begin
      clearing_in = clearing_ff && (clr_cnt_ff != '1);
      clr_cnt_in  = clearing_ff ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // Each request touches at most one RAM entry and reads its result on the
   // next edge, so a read always sees every earlier write without forwarding.
   always_comb begin
      if (clearing_ff) begin
         sys_we    = 1'b1;
         sys_re    = 1'b0;
         sys_addr  = clr_cnt_ff[SYS_IDX_W-1:0];
         sys_wdata = sys_clear_value(clr_cnt_ff[SYS_IDX_W-1:0]);
         cart_we   = 1'b1;
         cart_re   = 1'b0;
         cart_addr = clr_cnt_ff;
      end else begin
         sys_we    = accept && map.sys_we;
         sys_re    = accept && map.sys_re;
         sys_addr  = map.sys_idx;
         sys_wdata = req_write_data;
         cart_we   = accept && map.cart_we;
         cart_re   = accept && map.cart_re;
         cart_addr = map.cart_idx;
      end
   end

   bmm_ram #(
      .DEPTH (SYS_RAM_DEPTH),
      .WIDTH (DATA_W)
   ) u_sys_ram (
      .clock (clock),
      .we    (sys_we),
      .re    (sys_re),
      .addr  (sys_addr),
      .wdata (sys_wdata),
      .rdata (sys_q)
   );

   bmm_ram #(
      .DEPTH (CART_RAM_DEPTH),
      .WIDTH (DATA_W)
   ) u_cart_ram (
      .clock (clock),
      .we    (cart_we),
      .re    (cart_re),
      .addr  (cart_addr),
      .wdata (clearing_ff ? '0 : req_write_data),
      .rdata (cart_q)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (rsp_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff    <= map.src;
         s1_rom_ff    <= map.rom_address;
         s1_bat_ff    <= battery_in;
         s1_ram_rd_ff <= map.sys_re || map.cart_re;
      end
   end

   assign rsp_valid        = s1_valid_ff;
   assign rsp_source       = s1_src_ff;
   assign rsp_rom_address  = s1_rom_ff;
   assign rsp_battery_used = s1_bat_ff;

   always_comb begin
      if (!s1_ram_rd_ff) begin
         rsp_read_data = '0;
      end else if (s1_src_ff == SRC_CART) begin
         rsp_read_data = cart_q;
      end else begin
         rsp_read_data = sys_q;
      end
   end

   `BMM_ASSERT_IMPL(a_no_accept_while_clearing, clock, reset, clearing_ff, !req_ready)
   `BMM_ASSERT_NEXT(a_accept_gives_response, clock, reset, accept, rsp_valid)
   `BMM_ASSERT_IMPL(a_ignored_write_is_blank, clock, reset, rsp_valid && (rsp_source == SRC_NONE), (rsp_rom_address == '0) && (rsp_read_data == '0))
   `BMM_ASSERT_IMPL(a_ram_read_has_no_rom, clock, reset, rsp_valid && s1_ram_rd_ff, (rsp_rom_address == '0) && ((rsp_source == SRC_SYS) || (rsp_source == SRC_CART)))
   `BMM_ASSERT_NEXT(a_battery_sticky, clock, reset, s1_bat_ff && !clearing_ff, s1_bat_ff)

endmodule

/* sim/banked_memory_mapper_test.sv */
`timescale 1ns / 100ps

module banked_memory_mapper_test;
   import bmm_pkg::*;

   localparam int CLOCK_PERIOD = 2;
   localparam int RESET_CYCLES = 8;
   localparam int IDLE_PERCENT = 16;
   localparam int STALL_LIMIT  = 200000;
   localparam int END_CYCLES   = 8;
   localparam int RANDOM_ITEMS = 720;

   localparam logic CMD_READ = ~CMD_WRITE;
   localparam logic [ADDR_W-1:0] CART_BASE = 16'h8000;
   localparam logic [ADDR_W-1:0] SYS_BASE  = 16'hC000;
   localparam logic [DATA_W-1:0] CTRL_ENABLE  = DATA_W'(1) << CTRL_RAM_EN_BIT;
   localparam logic [DATA_W-1:0] CTRL_UPPER   = DATA_W'(1) << CTRL_RAM_BANK_BIT;

   typedef struct packed {
      source_type        source;
      logic [ROM_W-1:0]  rom_address;
      logic [DATA_W-1:0] read_data;
      logic              battery_used;
   } bus_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_cmd = 1'b0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_source;
   logic [ROM_W-1:0]    rsp_rom_address;
   logic [DATA_W-1:0]   rsp_read_data;
   logic                rsp_battery_used;

   // Mirror of the mapper's registers and memories.
   logic [1:0]          cart_mode;      // bit 1 enable, bit 0 upper half
   logic [BANK_W-1:0]   rom_bank [3];
   logic [DATA_W-1:0]   sys_mem [SYS_RAM_DEPTH];
   logic [DATA_W-1:0]   cart_mem [CART_RAM_DEPTH];
   logic                battery_seen;

   bus_result_type      mapped_results [$];
   int unsigned         mismatch_count = 0;
   int unsigned         source_count [4] = '{0, 0, 0, 0};
   int unsigned         register_writes = 0;
   int unsigned         quiet_cycles = 0;
   bit                  steady = 1'b0;

   banked_memory_mapper i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_source       (rsp_source),
      .rsp_rom_address  (rsp_rom_address),
      .rsp_read_data    (rsp_read_data),
      .rsp_battery_used (rsp_battery_used)
   );

   always #(CLOCK_PERIOD / 2.0) clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   // Decodes one bus access against the mirrored state and applies its writes.
   function automatic bus_result_type map_access(input logic cmd,
                                                 input logic [ADDR_W-1:0] addr,
                                                 input logic [DATA_W-1:0] data);
      bus_result_type r;
      logic [SYS_IDX_W-1:0] sys_idx;
      logic [CART_IDX_W-1:0] cart_idx;
      logic [1:0] slot;
      r.source = SRC_NONE;
      r.rom_address = '0;
      r.read_data = '0;
      sys_idx = addr[SYS_IDX_W-1:0];
      cart_idx = {cart_mode[0], addr[OFFSET_W-1:0]};
      slot = addr[ADDR_W-1:OFFSET_W];
      if (cmd != CMD_WRITE) begin
         if (addr < ADDR_BOOT_END) begin
            r.source = SRC_ROM;
            r.rom_address = ROM_W'(addr) & ROM_MASK;
         end else if (addr < SYS_BASE) begin
            if (slot == SLOT_CART && cart_mode[1]) begin
               r.source = SRC_CART;
               r.read_data = cart_mem[cart_idx];
            end else begin
               r.source = SRC_ROM;
               r.rom_address = {rom_bank[slot], addr[OFFSET_W-1:0]} & ROM_MASK;
            end
         end else begin
            r.source = SRC_SYS;
            r.read_data = sys_mem[sys_idx];
         end
      end else if (addr >= CART_BASE && addr < SYS_BASE) begin
         if (cart_mode[1]) begin
            r.source = SRC_CART;
            cart_mem[cart_idx] = data;
         end
      end else if (addr >= SYS_BASE) begin
         r.source = SRC_SYS;
         sys_mem[sys_idx] = data;
         if (addr == ADDR_CTRL) begin
            cart_mode = {data[CTRL_RAM_EN_BIT], data[CTRL_RAM_BANK_BIT]};
            if (data[CTRL_RAM_EN_BIT]) begin
               battery_seen = 1'b1;
            end
         end else if (addr >= ADDR_BANK0) begin
            rom_bank[2'(addr - ADDR_BANK0)] = data[BANK_W-1:0];
         end
      end
      r.battery_used = battery_seen;
      return r;
   endfunction

   // Entered and left just after a rising edge; valid only drops for idle gaps.
   task automatic send_access(input logic cmd, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
      bus_result_type want;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_address    <= addr;
      req_write_data <= data;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      want = map_access(cmd, addr, data);
      mapped_results.push_back(want);
      source_count[want.source]++;
      if (cmd == CMD_WRITE && addr >= ADDR_CTRL) begin
         register_writes++;
      end
   endtask

   task automatic drain_responses;
      req_valid <= 1'b0;
      do @(posedge clock); while (mapped_results.size() != 0);
   endtask

   task automatic report_mismatch(input string text);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: %s", $realtime, text);
      end
   endtask

   // Sampled at the falling edge, so the values are settled before the accepting edge.
   always @(negedge clock) begin : response_check
      bus_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (mapped_results.size() == 0) begin
            report_mismatch($sformatf("response with nothing awaited: source %0d rom %h data %h",
                                      rsp_source, rsp_rom_address, rsp_read_data));
         end else begin
            want = mapped_results.pop_front();
            if (rsp_source !== want.source || rsp_rom_address !== want.rom_address ||
                rsp_read_data !== want.read_data || rsp_battery_used !== want.battery_used) begin
               report_mismatch($sformatf(
                  "expected source %0d rom %h data %h battery %b, got %0d %h %h %b",
                  want.source, want.rom_address, want.read_data, want.battery_used,
                  rsp_source, rsp_rom_address, rsp_read_data, rsp_battery_used));
            end
         end
      end
   end

   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or response moved for %0d cycles", quiet_cycles);
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic test_reset_state;
      send_access(CMD_READ, ADDR_CTRL, 8'h00);
      send_access(CMD_READ, ADDR_BANK0, 8'h00);
      send_access(CMD_READ, ADDR_BANK1, 8'h00);
      send_access(CMD_READ, ADDR_BANK2, 8'h00);
      send_access(CMD_READ, 16'h0000, 8'h00);
      send_access(CMD_READ, 16'h4000, 8'h00);
      send_access(CMD_READ, 16'hBFFF, 8'h00);
   endtask

   // Bank numbers are masked to six bits; the first kilobyte ignores slot 0's bank.
   task automatic test_bank_registers;
      send_access(CMD_WRITE, ADDR_BANK0, 8'hFF);
      send_access(CMD_WRITE, ADDR_BANK1, 8'hC0);
      send_access(CMD_WRITE, ADDR_BANK2, 8'h3F);
      send_access(CMD_READ, 16'h03FF, 8'hFF);
      send_access(CMD_READ, ADDR_BOOT_END, 8'hFF);
      send_access(CMD_READ, 16'h7FFF, 8'h00);
      send_access(CMD_READ, CART_BASE, 8'hFF);
   endtask

   task automatic test_cart_ram;
      send_access(CMD_WRITE, CART_BASE, 8'h5A);
      send_access(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE);
      send_access(CMD_WRITE, CART_BASE, 8'hA5);
      send_access(CMD_READ, CART_BASE, 8'h00);
      send_access(CMD_WRITE, ADDR_CTRL, CTRL_ENABLE | CTRL_UPPER);
      send_access(CMD_READ, CART_BASE, 8'h00);
      send_access(CMD_WRITE, 16'hBFFF, 8'hFF);
      // Every bit except enable and upper half: cart RAM off, battery flag kept.
      send_access(CMD_WRITE, ADDR_CTRL, ~(CTRL_ENABLE | CTRL_UPPER));
      send_access(CMD_READ, 16'hBFFF, 8'h00);
   endtask

   task automatic test_system_ram_and_ignored_writes;
      send_access(CMD_WRITE, 16'h0000, 8'hFF);
      send_access(CMD_WRITE, 16'h7FFF, 8'h00);
      send_access(CMD_WRITE, SYS_BASE, 8'h81);
      send_access(CMD_READ, 16'hE000, 8'hFF);
   endtask

   // Many accesses go to a handful of offsets per region, so writes are read back
   // and the cart RAM is switched on and off often.
   task automatic test_random_traffic;
      int unsigned sent;
      int unsigned pick;
      logic cmd;
      logic [ADDR_W-1:0] addr;
      logic [DATA_W-1:0] data;
      logic [OFFSET_W-1:0] offset;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         steady <= (sent >= 200 && sent < 360);
         if (sent == 500) begin
            drain_responses();
         end
         pick = $urandom_range(99);
         data = DATA_W'($urandom);
         if (pick < 12) begin
            cmd = ($urandom_range(99) < 80) ? CMD_WRITE : CMD_READ;
            addr = ADDR_CTRL + ADDR_W'($urandom_range(3));
         end else if (pick < 22) begin
            cmd = 1'($urandom);
            addr = ADDR_W'($urandom);
         end else begin
            cmd = 1'($urandom);
            offset = $urandom_range(1) ? OFFSET_W'($urandom) : OFFSET_W'($urandom_range(15));
            if ($urandom_range(3) == 0) begin
               offset[OFFSET_W-1] = 1'b1;
            end
            addr = {2'($urandom), offset};
         end
         send_access(cmd, addr, data);
         sent++;
      end
      steady <= 1'b0;
   endtask

   initial begin
      cart_mode = 2'b00;
      rom_bank[0] = BANK0_RESET;
      rom_bank[1] = BANK1_RESET;
      rom_bank[2] = BANK2_RESET;
      foreach (sys_mem[i]) sys_mem[i] = '0;
      foreach (cart_mem[i]) cart_mem[i] = '0;
      sys_mem[SYS_IDX_W'(ADDR_BANK1)] = DATA_W'(BANK1_RESET);
      sys_mem[SYS_IDX_W'(ADDR_BANK2)] = DATA_W'(BANK2_RESET);
      battery_seen = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_bank_registers();
      test_cart_ram();
      test_system_ram_and_ignored_writes();
      test_random_traffic();
      drain_responses();
      repeat (END_CYCLES) @(posedge clock);

      $display("Run covered %0d ROM reads, %0d system RAM and %0d cart RAM accesses, %0d ignored",
               source_count[SRC_ROM], source_count[SRC_SYS], source_count[SRC_CART],
               source_count[SRC_NONE]);
      $display("with %0d control and bank register writes; %0d responses disagreed",
               register_writes, mismatch_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
